FILE: rtl/core/aft_pkg.sv
package aft_pkg;

   // Port and arithmetic widths. Coefficients are stored at the port width.
   localparam int DATA_WIDTH   = 32;
   localparam int OPCODE_WIDTH = 3;
   localparam int INDEX_WIDTH  = 4;
   localparam int COEFF_WIDTH  = DATA_WIDTH;
   localparam int FRAC_BITS    = 16;
   localparam int DIFF_WIDTH   = COEFF_WIDTH + 1;
   localparam int PROD_WIDTH   = COEFF_WIDTH + DIFF_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + 2;

   // Matrix shape: three rows, three linear columns plus translation.
   localparam int DIM      = 3;
   localparam int COLS     = 4;
   localparam int MAT_SIZE = DIM * COLS;

   // Queue depths between the front end, the back end and the result port.
   localparam int CMD_DEPTH     = 2;
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_CNT_WIDTH = $clog2(RSP_DEPTH + 1);

   typedef logic signed [DATA_WIDTH-1:0]  data_type;
   typedef logic signed [COEFF_WIDTH-1:0] coeff_type;

   // Fixed-point 1.0 for the identity diagonal.
   localparam coeff_type COEFF_ONE = coeff_type'(64'(1) << FRAC_BITS);

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_LOAD_CUR  = 3'd0,
      OP_LOAD_OPD  = 3'd1,
      OP_XFORM     = 3'd2,
      OP_INV_XFORM = 3'd3,
      OP_APPEND    = 3'd4,
      OP_PREPEND   = 3'd5,
      OP_READ_COL  = 3'd6,
      OP_IDENTITY  = 3'd7
   } opcode_type;

   // Request classes handed from the front end to the back end.
   typedef enum logic [3:0] {
      K_NOP,
      K_LOAD_CUR,
      K_LOAD_OPD,
      K_XFORM,
      K_INV,
      K_APPEND,
      K_PREPEND,
      K_READ_COL,
      K_READ_ZERO,
      K_IDENT
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [INDEX_WIDTH-1:0]  index;
      data_type                value;
      data_type                point_x;
      data_type                point_y;
      data_type                point_z;
   } cmd_type;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
   } rsp_type;

endpackage

FILE: rtl/core/aft_front.sv
module aft_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [aft_pkg::OPCODE_WIDTH-1:0]  opcode,
   input  logic [aft_pkg::INDEX_WIDTH-1:0]   coeff_index,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    coeff_value,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    point_x,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    point_y,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    point_z,
   output logic                              cmd_valid,
   output aft_pkg::cmd_type                  cmd,
   input  logic                              cmd_pop
);
   import aft_pkg::*;

   localparam int PTR_WIDTH = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(CMD_DEPTH + 1);

   kind_type               kind;
   cmd_type                decoded;
   logic                   accept;
   logic                   store;
   logic                   take;

   cmd_type                queue_ff [CMD_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   // Classify the request; loads outside the matrix carry no work and are dropped.
   always_comb begin
      unique case (opcode_type'(opcode))
         OP_LOAD_CUR:  kind = (coeff_index < INDEX_WIDTH'(MAT_SIZE)) ? K_LOAD_CUR : K_NOP;
         OP_LOAD_OPD:  kind = (coeff_index < INDEX_WIDTH'(MAT_SIZE)) ? K_LOAD_OPD : K_NOP;
         OP_XFORM:     kind = K_XFORM;
         OP_INV_XFORM: kind = K_INV;
         OP_APPEND:    kind = K_APPEND;
         OP_PREPEND:   kind = K_PREPEND;
         OP_READ_COL:  kind = (coeff_index < INDEX_WIDTH'(COLS)) ? K_READ_COL : K_READ_ZERO;
         OP_IDENTITY:  kind = K_IDENT;
         default:      kind = K_NOP;
      endcase
   end

   always_comb begin
      decoded.kind    = kind;
      decoded.index   = coeff_index;
      decoded.value   = coeff_value;
      decoded.point_x = point_x;
      decoded.point_y = point_y;
      decoded.point_z = point_z;
   end

   // Request queue toward the back end.
   assign full      = (count_ff == CNT_WIDTH'(CMD_DEPTH));
   assign accept    = push & ~full;
   assign store     = accept & (kind != K_NOP);
   assign cmd_valid = (count_ff != '0);
   assign take      = cmd_pop & cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (store) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (store && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !store) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: rtl/core/aft_exec.sv
module aft_exec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  aft_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   input  logic [aft_pkg::RSP_CNT_WIDTH-1:0] rsp_count,
   output logic                              rsp_push,
   output aft_pkg::rsp_type                  rsp_data
);
   import aft_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_COMBINE,
      ST_DRAIN
   } state_type;

   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [ACC_WIDTH-1:0]  acc_type;

   localparam logic [1:0] TRANS_COL = 2'(COLS - 1);
   localparam coeff_type  COEFF_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
   localparam coeff_type  COEFF_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

   // Row-major coefficient address of (row, col).
   function automatic logic [INDEX_WIDTH-1:0] mat_at(input logic [1:0] row,
                                                     input logic [1:0] col);
      return {row, col};
   endfunction

   // Saturate an aligned sum to the coefficient width.
   function automatic coeff_type sat_coeff(input acc_type v);
      logic [ACC_WIDTH-COEFF_WIDTH:0] upper;
      upper = v[ACC_WIDTH-1:COEFF_WIDTH-1];
      if ((&upper) || (~|upper)) begin
         return v[COEFF_WIDTH-1:0];
      end else if (v[ACC_WIDTH-1]) begin
         return COEFF_MIN;
      end else begin
         return COEFF_MAX;
      end
   endfunction

   // Matrix state and sequencer.
   coeff_type              cur_ff [MAT_SIZE];
   coeff_type              cur_in [MAT_SIZE];
   coeff_type              opd_ff [MAT_SIZE];
   coeff_type              opd_in [MAT_SIZE];
   coeff_type              new_ff [DIM][DIM];
   coeff_type              new_in [DIM][DIM];
   state_type              state_ff, state_in;
   logic [1:0]             pass_ff, pass_in;
   logic                   drain_ff, drain_in;
   logic                   prepend_ff, prepend_in;

   // Issue controls.
   logic                   do_issue;
   logic                   do_res;
   logic                   do_comb;
   logic                   credit_ok;
   logic [RSP_CNT_WIDTH:0] in_flight;
   kind_type               op_kind;
   logic [1:0]             col_sel;
   data_type               pt [DIM];
   coeff_type              col_v [DIM];

   // Operand stage.
   coeff_type              a_in [DIM][DIM];
   diff_type               b_in [DIM][DIM];
   coeff_type              off_in [DIM];
   coeff_type              a_ff [DIM][DIM];
   diff_type               b_ff [DIM][DIM];
   coeff_type              off_ff [DIM];
   logic                   s1_valid_ff, s1_res_ff, s1_comb_ff;
   logic [1:0]             s1_col_ff;

   // Product stage.
   prod_type               prod_ff [DIM][DIM];
   coeff_type              off2_ff [DIM];
   logic                   s2_valid_ff, s2_res_ff, s2_comb_ff;
   logic [1:0]             s2_col_ff;

   // Sum stage.
   acc_type                acc_v [DIM];
   coeff_type              res_v [DIM];

   assign pt[0] = cmd.point_x;
   assign pt[1] = cmd.point_y;
   assign pt[2] = cmd.point_z;

   // Results that may still land in the output queue must fit there.
   assign in_flight = {1'b0, rsp_count}
                    + (RSP_CNT_WIDTH+1)'(s1_valid_ff & s1_res_ff)
                    + (RSP_CNT_WIDTH+1)'(s2_valid_ff & s2_res_ff);
   assign credit_ok = (in_flight < (RSP_CNT_WIDTH+1)'(RSP_DEPTH));

   // A combine pass takes its kind from the latched flag, everything else from the queue head.
   always_comb begin
      if (state_ff == ST_COMBINE) begin
         op_kind = prepend_ff ? K_PREPEND : K_APPEND;
         col_sel = pass_ff;
      end else begin
         op_kind = cmd.kind;
         col_sel = cmd.index[1:0];
      end
   end

   // One column of the matrix on the right-hand side of a product or of a column read.
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         if (op_kind == K_PREPEND) begin
            col_v[k] = opd_ff[mat_at(2'(k), col_sel)];
         end else begin
            col_v[k] = cur_ff[mat_at(2'(k), col_sel)];
         end
      end
   end

   // Operand selection for the nine multipliers and the three offsets.
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         off_in[r] = '0;
         for (int k = 0; k < DIM; k++) begin
            a_in[r][k] = '0;
            b_in[r][k] = '0;
         end
      end
      unique case (op_kind)
         K_XFORM: begin
            for (int r = 0; r < DIM; r++) begin
               off_in[r] = cur_ff[mat_at(2'(r), TRANS_COL)];
               for (int k = 0; k < DIM; k++) begin
                  a_in[r][k] = cur_ff[mat_at(2'(r), 2'(k))];
                  b_in[r][k] = diff_type'(pt[k]);
               end
            end
         end
         K_INV: begin
            for (int r = 0; r < DIM; r++) begin
               for (int k = 0; k < DIM; k++) begin
                  a_in[r][k] = cur_ff[mat_at(2'(k), 2'(r))];
                  b_in[r][k] = diff_type'(pt[k])
                             - diff_type'(cur_ff[mat_at(2'(k), TRANS_COL)]);
               end
            end
         end
         K_READ_COL: begin
            for (int r = 0; r < DIM; r++) begin
               off_in[r] = col_v[r];
            end
         end
         K_APPEND: begin
            for (int r = 0; r < DIM; r++) begin
               off_in[r] = (pass_ff == TRANS_COL) ? opd_ff[mat_at(2'(r), TRANS_COL)] : '0;
               for (int k = 0; k < DIM; k++) begin
                  a_in[r][k] = opd_ff[mat_at(2'(r), 2'(k))];
                  b_in[r][k] = diff_type'(col_v[k]);
               end
            end
         end
         K_PREPEND: begin
            for (int r = 0; r < DIM; r++) begin
               off_in[r] = (pass_ff == TRANS_COL) ? cur_ff[mat_at(2'(r), TRANS_COL)] : '0;
               for (int k = 0; k < DIM; k++) begin
                  a_in[r][k] = cur_ff[mat_at(2'(r), 2'(k))];
                  b_in[r][k] = diff_type'(col_v[k]);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Sum, align and saturate each row.
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         acc_v[r] = acc_type'(prod_ff[r][0]) + acc_type'(prod_ff[r][1])
                  + acc_type'(prod_ff[r][2]) + (acc_type'(off2_ff[r]) <<< FRAC_BITS);
         res_v[r] = sat_coeff(acc_v[r] >>> FRAC_BITS);
      end
   end

   assign rsp_push   = s2_valid_ff & s2_res_ff;
   assign rsp_data.x = res_v[0];
   assign rsp_data.y = res_v[1];
   assign rsp_data.z = res_v[2];

   // Sequencer: immediate state updates, issue of point work, and the four combine passes.
   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      drain_in   = drain_ff;
      prepend_in = prepend_ff;
      cmd_pop    = 1'b0;
      do_issue   = 1'b0;
      do_res     = 1'b0;
      do_comb    = 1'b0;
      cur_in     = cur_ff;
      opd_in     = opd_ff;
      new_in     = new_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  K_LOAD_CUR: begin
                     cur_in[cmd.index] = cmd.value;
                     cmd_pop = 1'b1;
                  end
                  K_LOAD_OPD: begin
                     opd_in[cmd.index] = cmd.value;
                     cmd_pop = 1'b1;
                  end
                  K_IDENT: begin
                     for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < COLS; c++) begin
                           cur_in[mat_at(2'(r), 2'(c))] = (r == c) ? COEFF_ONE : '0;
                        end
                     end
                     cmd_pop = 1'b1;
                  end
                  K_XFORM, K_INV, K_READ_COL, K_READ_ZERO: begin
                     if (credit_ok) begin
                        cmd_pop  = 1'b1;
                        do_issue = 1'b1;
                        do_res   = 1'b1;
                     end
                  end
                  K_APPEND, K_PREPEND: begin
                     cmd_pop    = 1'b1;
                     prepend_in = (cmd.kind == K_PREPEND);
                     pass_in    = '0;
                     state_in   = ST_COMBINE;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_COMBINE: begin
            do_issue = 1'b1;
            do_comb  = 1'b1;
            pass_in  = pass_ff + 2'd1;
            if (pass_ff == TRANS_COL) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // Combine columns collect in a buffer; the last one commits the whole matrix.
      if (s2_valid_ff && s2_comb_ff) begin
         if (s2_col_ff == TRANS_COL) begin
            for (int r = 0; r < DIM; r++) begin
               for (int c = 0; c < DIM; c++) begin
                  cur_in[mat_at(2'(r), 2'(c))] = new_ff[r][c];
               end
               cur_in[mat_at(2'(r), TRANS_COL)] = res_v[r];
            end
         end else begin
            for (int r = 0; r < DIM; r++) begin
               new_in[r][s2_col_ff] = res_v[r];
            end
         end
      end
   end

   // Control state, matrices and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         pass_ff     <= '0;
         drain_ff    <= 1'b0;
         prepend_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_res_ff   <= 1'b0;
         s1_comb_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_res_ff   <= 1'b0;
         s2_comb_ff  <= 1'b0;
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < COLS; c++) begin
               cur_ff[mat_at(2'(r), 2'(c))] <= (r == c) ? COEFF_ONE : '0;
               opd_ff[mat_at(2'(r), 2'(c))] <= '0;
            end
         end
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         drain_ff    <= drain_in;
         prepend_ff  <= prepend_in;
         s1_valid_ff <= do_issue;
         s1_res_ff   <= do_res;
         s1_comb_ff  <= do_comb;
         s2_valid_ff <= s1_valid_ff;
         s2_res_ff   <= s1_res_ff;
         s2_comb_ff  <= s1_comb_ff;
         cur_ff      <= cur_in;
         opd_ff      <= opd_in;
      end
   end

   // Datapath registers: operands, products and the combine column buffer.
   always_ff @(posedge clock) begin
      s1_col_ff <= pass_ff;
      s2_col_ff <= s1_col_ff;
      new_ff    <= new_in;
      for (int r = 0; r < DIM; r++) begin
         off_ff[r]  <= off_in[r];
         off2_ff[r] <= off_ff[r];
         for (int k = 0; k < DIM; k++) begin
            a_ff[r][k]    <= a_in[r][k];
            b_ff[r][k]    <= b_in[r][k];
            prod_ff[r][k] <= prod_type'(a_ff[r][k]) * prod_type'(b_ff[r][k]);
         end
      end
   end

endmodule

FILE: rtl/core/aft_rsp_fifo.sv
module aft_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_push,
   input  aft_pkg::rsp_type                  wr_data,
   input  logic                              pop,
   output logic                              empty,
   output aft_pkg::rsp_type                  head,
   output logic [aft_pkg::RSP_CNT_WIDTH-1:0] count
);
   import aft_pkg::*;

   localparam int PTR_WIDTH = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;

   rsp_type                  queue_ff [RSP_DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     take;

   assign empty = (count_ff == '0);
   assign take  = pop & ~empty;
   assign head  = queue_ff[rd_ptr_ff];
   assign count = count_ff;

   // Pointer and fill tracking; the back end never pushes into a full queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !wr_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_push) begin
         queue_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/affine_transform_3x4_engine_unit.sv
// A transform or column read passes the request queue, operand and product registers and result queue.
// Throughput: one request per cycle for loads, identity, transforms and column reads, while no combine
// runs and, for results, the result queue has room; the nine back-end multipliers take one point per cycle.
// Append and prepend hold the back end for a setup step, four column passes and a drain to commit.
// Reset empties both queues, sets the current matrix to identity and clears the operand matrix.
module affine_transform_3x4_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [aft_pkg::OPCODE_WIDTH-1:0]  req_opcode,
   input  logic [aft_pkg::INDEX_WIDTH-1:0]   req_coeff_index,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    req_coeff_value,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    req_point_x,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    req_point_y,
   input  logic [aft_pkg::DATA_WIDTH-1:0]    req_point_z,
   output logic                              empty,
   input  logic                              pop,
   output logic [aft_pkg::DATA_WIDTH-1:0]    rsp_out_x,
   output logic [aft_pkg::DATA_WIDTH-1:0]    rsp_out_y,
   output logic [aft_pkg::DATA_WIDTH-1:0]    rsp_out_z
);
   import aft_pkg::*;

   logic                     cmd_valid;
   cmd_type                  cmd;
   logic                     cmd_pop;
   logic                     rsp_push;
   rsp_type                  rsp_data;
   rsp_type                  rsp_head;
   logic [RSP_CNT_WIDTH-1:0] rsp_count;

   // Front end: classify requests and queue them.
   aft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .opcode      (req_opcode),
      .coeff_index (req_coeff_index),
      .coeff_value (req_coeff_value),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // Back end: matrices, multiplier array and combine sequencer.
   aft_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // Result queue toward the consumer.
   aft_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_push (rsp_push),
      .wr_data (rsp_data),
      .pop     (pop),
      .empty   (empty),
      .head    (rsp_head),
      .count   (rsp_count)
   );

   assign rsp_out_x = rsp_head.x;
   assign rsp_out_y = rsp_head.y;
   assign rsp_out_z = rsp_head.z;

endmodule

FILE: verif/tb.sv
module tb;
   import aft_pkg::*;

   typedef logic signed [127:0] wide_t;

   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 400000;

   // Predicts the engine's results and holds them until the result port delivers them.
   class affine_scoreboard;
      coeff_type cur_mat[MAT_SIZE];
      coeff_type opd_mat[MAT_SIZE];
      rsp_type   expected_q[$];
      int        error_count;

      function new();
         set_identity();
         foreach (opd_mat[k]) opd_mat[k] = '0;
         error_count = 0;
      endfunction

      function void set_identity();
         foreach (cur_mat[k]) cur_mat[k] = '0;
         cur_mat[0]  = COEFF_ONE;
         cur_mat[5]  = COEFF_ONE;
         cur_mat[10] = COEFF_ONE;
      endfunction

      // Coefficients and outputs share the 32-bit width, so one clamp serves both.
      function data_type clamp32(wide_t v);
         wide_t top;
         wide_t bottom;
         top    = 32'sh7fffffff;
         bottom = -top - 1;
         if (v > top) return 32'sh7fffffff;
         if (v < bottom) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Three exact products plus an aligned offset, floored by the fraction bits.
      function data_type dot_sum(wide_t a0, wide_t b0, wide_t a1, wide_t b1,
                                 wide_t a2, wide_t b2, wide_t offset);
         wide_t acc;
         acc = (offset <<< FRAC_BITS) + a0 * b0 + a1 * b1 + a2 * b2;
         return clamp32(acc >>> FRAC_BITS);
      endfunction

      // The current matrix becomes lhs * rhs; both inputs are copies of the old values.
      function void combine(coeff_type lhs[MAT_SIZE], coeff_type rhs[MAT_SIZE]);
         coeff_type fresh[MAT_SIZE];
         int r;
         int c;
         for (r = 0; r < DIM; r++) begin
            for (c = 0; c < COLS; c++) begin
               fresh[r*COLS+c] = dot_sum(lhs[r*COLS], rhs[c], lhs[r*COLS+1], rhs[COLS+c],
                                         lhs[r*COLS+2], rhs[2*COLS+c],
                                         (c == COLS - 1) ? lhs[r*COLS+3] : 0);
            end
         end
         cur_mat = fresh;
      endfunction

      // Applies one accepted request and queues the result it causes, if any.
      function void note_request(opcode_type op, logic [INDEX_WIDTH-1:0] idx, data_type val,
                                 data_type px, data_type py, data_type pz);
         data_type outs[DIM];
         wide_t    diff[DIM];
         data_type pt[DIM];
         rsp_type  res;
         bit       emits;
         int       r;
         emits = 1'b0;
         pt[0] = px;
         pt[1] = py;
         pt[2] = pz;
         case (op)
            OP_LOAD_CUR: begin
               if (idx < MAT_SIZE) cur_mat[idx] = val;
            end
            OP_LOAD_OPD: begin
               if (idx < MAT_SIZE) opd_mat[idx] = val;
            end
            OP_XFORM: begin
               for (r = 0; r < DIM; r++)
                  outs[r] = dot_sum(cur_mat[r*COLS], px, cur_mat[r*COLS+1], py,
                                    cur_mat[r*COLS+2], pz, cur_mat[r*COLS+3]);
               emits = 1'b1;
            end
            OP_INV_XFORM: begin
               // The difference, which needs 33 bits, is kept exact in a wide value before the transposed product.
               for (r = 0; r < DIM; r++) begin
                  diff[r] = pt[r];
                  diff[r] = diff[r] - cur_mat[r*COLS+3];
               end
               for (r = 0; r < DIM; r++)
                  outs[r] = dot_sum(cur_mat[r], diff[0], cur_mat[COLS+r], diff[1],
                                    cur_mat[2*COLS+r], diff[2], 0);
               emits = 1'b1;
            end
            OP_APPEND: combine(opd_mat, cur_mat);
            OP_PREPEND: combine(cur_mat, opd_mat);
            OP_READ_COL: begin
               for (r = 0; r < DIM; r++)
                  outs[r] = (idx < COLS) ? cur_mat[r*COLS+idx] : '0;
               emits = 1'b1;
            end
            default: set_identity();
         endcase
         if (emits) begin
            res.x = outs[0];
            res.y = outs[1];
            res.z = outs[2];
            expected_q.push_back(res);
         end
      endfunction

      function void compare_field(string name, data_type want, data_type got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      // Compares one delivered result with the oldest prediction.
      function void check_result(data_type x, data_type y, data_type z);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result with no request waiting: x=%0d y=%0d z=%0d", x, y, z);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_x", want.x, x);
         compare_field("out_y", want.y, y);
         compare_field("out_z", want.z, z);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic [OPCODE_WIDTH-1:0] req_opcode;
   logic [INDEX_WIDTH-1:0]  req_coeff_index;
   logic [DATA_WIDTH-1:0]   req_coeff_value;
   logic [DATA_WIDTH-1:0]   req_point_x;
   logic [DATA_WIDTH-1:0]   req_point_y;
   logic [DATA_WIDTH-1:0]   req_point_z;
   logic                    empty;
   logic                    pop;
   logic [DATA_WIDTH-1:0]   rsp_out_x;
   logic [DATA_WIDTH-1:0]   rsp_out_y;
   logic [DATA_WIDTH-1:0]   rsp_out_z;

   affine_scoreboard sb;
   bit               steady;
   int               items_sent;
   int               cycle_count;
   int               pop_wait;

   affine_transform_3x4_engine_unit uut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Mostly back to back, sometimes a short gap, rarely a long pause; always back to back while steady.
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic data_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'sh7fffffff;
      if (roll == 1) return 32'sh80000000;
      if (roll < 5) return data_type'($urandom);
      return data_type'(int'($urandom_range(0, 196608)) - 98304);
   endfunction

   function automatic data_type pick_point();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'sh7fffffff;
      if (roll == 1) return 32'sh80000000;
      if (roll < 5) return data_type'($urandom);
      return data_type'(int'($urandom_range(0, 33554432)) - 16777216);
   endfunction

   // Sampled before the edge's updates, so the driver and this monitor agree.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset) begin
         if (push && !full)
            sb.note_request(opcode_type'(req_opcode), req_coeff_index, req_coeff_value,
                            req_point_x, req_point_y, req_point_z);
         if (pop && !empty)
            sb.check_result(rsp_out_x, rsp_out_y, rsp_out_z);
      end
   end

   // Result side stalls at random.
   always @(negedge clock) begin
      if (pop_wait > 0) begin
         pop <= 1'b0;
         pop_wait = pop_wait - 1;
      end else begin
         pop <= 1'b1;
         pop_wait = gap_len();
      end
   end

   // Presents one request after a random gap and holds it until it is accepted.
   task automatic send_request(opcode_type op, logic [INDEX_WIDTH-1:0] idx, data_type val,
                               data_type px, data_type py, data_type pz);
      int gap;
      gap = gap_len();
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      req_opcode      <= op;
      req_coeff_index <= idx;
      req_coeff_value <= val;
      req_point_x     <= px;
      req_point_y     <= py;
      req_point_z     <= pz;
      push            <= 1'b1;
      do @(posedge clock); while (full);
      if (!((op == OP_LOAD_CUR || op == OP_LOAD_OPD) && idx >= MAT_SIZE)) items_sent++;
   endtask

   task automatic send_simple(opcode_type op, logic [INDEX_WIDTH-1:0] idx, data_type val);
      send_request(op, idx, val, pick_point(), pick_point(), pick_point());
   endtask

   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   // A rigid matrix built from a signed cyclic permutation, then points through both ways.
   task automatic run_rigid_sequence();
      int       rot;
      int       r;
      int       c;
      data_type coeff;
      rot = $urandom_range(0, DIM - 1);
      send_simple(OP_IDENTITY, INDEX_WIDTH'($urandom), pick_value());
      for (r = 0; r < DIM; r++) begin
         for (c = 0; c < DIM; c++) begin
            coeff = '0;
            if (c == (r + rot) % DIM)
               coeff = $urandom_range(0, 1) ? COEFF_ONE : -COEFF_ONE;
            send_simple(OP_LOAD_CUR, INDEX_WIDTH'(r * COLS + c), coeff);
         end
         send_simple(OP_LOAD_CUR, INDEX_WIDTH'(r * COLS + 3), pick_value());
      end
      repeat (4)
         send_simple($urandom_range(0, 1) ? OP_XFORM : OP_INV_XFORM,
                     INDEX_WIDTH'($urandom), pick_value());
   endtask

   // Fills the whole operand matrix, folds it into the current one, then reads a column and transforms a point.
   task automatic run_operand_batch();
      int k;
      for (k = 0; k < MAT_SIZE; k++)
         send_simple(OP_LOAD_OPD, INDEX_WIDTH'(k), pick_value());
      send_simple($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND,
                  INDEX_WIDTH'($urandom), pick_value());
      send_simple(OP_READ_COL, INDEX_WIDTH'($urandom_range(0, 3)), pick_value());
      send_simple(OP_XFORM, INDEX_WIDTH'($urandom), pick_value());
   endtask

   task automatic random_item();
      int                     roll;
      opcode_type             op;
      logic [INDEX_WIDTH-1:0] idx;
      roll = $urandom_range(0, 99);
      idx  = INDEX_WIDTH'($urandom);
      if (roll < 14) op = OP_LOAD_CUR;
      else if (roll < 26) op = OP_LOAD_OPD;
      else if (roll < 58) op = OP_XFORM;
      else if (roll < 72) op = OP_INV_XFORM;
      else if (roll < 78) op = OP_APPEND;
      else if (roll < 84) op = OP_PREPEND;
      else if (roll < 95) op = OP_READ_COL;
      else op = OP_IDENTITY;
      if (op == OP_LOAD_CUR || op == OP_LOAD_OPD)
         idx = ($urandom_range(0, 9) == 0) ? INDEX_WIDTH'($urandom_range(12, 15))
                                           : INDEX_WIDTH'($urandom_range(0, 11));
      else if (op == OP_READ_COL)
         idx = ($urandom_range(0, 7) == 0) ? INDEX_WIDTH'($urandom_range(4, 15))
                                           : INDEX_WIDTH'($urandom_range(0, 3));
      send_simple(op, idx, pick_value());
   endtask

   initial begin
      int target;
      int last_toggle;
      int roll;
      bit drained;
      sb              = new();
      reset           = 1'b1;
      push            = 1'b0;
      pop             = 1'b0;
      req_opcode      = '0;
      req_coeff_index = '0;
      req_coeff_value = '0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_point_z     = '0;
      steady          = 1'b0;
      items_sent      = 0;
      cycle_count     = 0;
      pop_wait        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: columns of the reset matrix, out-of-range column and load indexes,
      // extreme coefficients and points, saturation, exact inverse difference,
      // operand folding both ways and identity.
      send_simple(OP_READ_COL, 0, 0);
      send_simple(OP_READ_COL, 3, 0);
      send_simple(OP_READ_COL, 4, 0);
      send_simple(OP_READ_COL, 15, 0);
      send_request(OP_XFORM, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
      send_simple(OP_LOAD_CUR, 3, 32'sh7fffffff);
      send_simple(OP_LOAD_CUR, 7, 32'sh80000000);
      send_simple(OP_LOAD_CUR, 12, 32'sh12345678);
      send_simple(OP_LOAD_CUR, 15, 32'sh80000000);
      send_request(OP_XFORM, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
      send_request(OP_INV_XFORM, 0, 0, 32'sh80000000, 32'sh7fffffff, 0);
      send_simple(OP_READ_COL, 3, 0);
      send_simple(OP_LOAD_OPD, 0, 32'sh80000000);
      send_simple(OP_LOAD_OPD, 5, 32'sh7fffffff);
      send_simple(OP_LOAD_OPD, 11, 32'sh7fffffff);
      send_simple(OP_LOAD_OPD, 15, 32'sh7fffffff);
      send_simple(OP_APPEND, 0, 0);
      send_simple(OP_READ_COL, 0, 0);
      send_simple(OP_PREPEND, 0, 0);
      send_simple(OP_READ_COL, 3, 0);
      send_simple(OP_IDENTITY, 0, 0);
      send_simple(OP_LOAD_CUR, 0, 32'sh7fffffff);
      send_request(OP_XFORM, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      send_request(OP_INV_XFORM, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
      send_simple(OP_IDENTITY, 0, 0);

      // Random traffic with occasional well-formed sequences and stretches without gaps.
      target      = items_sent + RANDOM_ITEMS;
      last_toggle = items_sent;
      drained     = 1'b0;
      while (items_sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) run_rigid_sequence();
         else if (roll < 10) run_operand_batch();
         else random_item();
         if (items_sent - last_toggle >= 40) begin
            steady      = ($urandom_range(0, 3) == 0);
            last_toggle = items_sent;
         end
         if (!drained && items_sent >= target - RANDOM_ITEMS / 2) begin
            drain_results();
            drained = 1'b1;
         end
      end

      // Let every outstanding result arrive, then allow for stray ones.
      drain_results();
      repeat (12) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/aft_pkg.sv
rtl/core/aft_front.sv
rtl/core/aft_exec.sv
rtl/core/aft_rsp_fifo.sv
rtl/core/affine_transform_3x4_engine_unit.sv
verif/tb.sv
